// ===== rtl/stl_pkg.sv =====
// Shared types and constants for the streaming token lexer.
// Used by the channel interfaces and the lexer core; no dependencies.
package stl_pkg;

	localparam int ByteW = 8;
	localparam int KindW = 5;

	typedef logic [ByteW-1:0] byte_t;
	typedef logic [KindW-1:0] kind_t;

	// Token kind codes.
	localparam kind_t K_ILLEGAL  = 5'd0;
	localparam kind_t K_EOF      = 5'd1;
	localparam kind_t K_SPACE    = 5'd2;
	localparam kind_t K_NEWLINE  = 5'd3;
	localparam kind_t K_ASSIGN   = 5'd4;
	localparam kind_t K_EQ       = 5'd5;
	localparam kind_t K_SEMI     = 5'd6;
	localparam kind_t K_LPAREN   = 5'd7;
	localparam kind_t K_RPAREN   = 5'd8;
	localparam kind_t K_COMMA    = 5'd9;
	localparam kind_t K_PLUS     = 5'd10;
	localparam kind_t K_MINUS    = 5'd11;
	localparam kind_t K_BANG     = 5'd12;
	localparam kind_t K_NOTEQ    = 5'd13;
	localparam kind_t K_SLASH    = 5'd14;
	localparam kind_t K_STAR     = 5'd15;
	localparam kind_t K_LT       = 5'd16;
	localparam kind_t K_GT       = 5'd17;
	localparam kind_t K_LBRACE   = 5'd18;
	localparam kind_t K_RBRACE   = 5'd19;
	localparam kind_t K_LBRACKET = 5'd20;
	localparam kind_t K_RBRACKET = 5'd21;
	localparam kind_t K_STRING   = 5'd22;
	localparam kind_t K_IDENT    = 5'd23;
	localparam kind_t K_INT      = 5'd24;

	// Characters with a special role.
	localparam byte_t CH_NUL    = 8'h00;
	localparam byte_t CH_ASSIGN = 8'h3D;
	localparam byte_t CH_BANG   = 8'h21;
	localparam byte_t CH_UNDER  = 8'h5F;
	localparam byte_t CH_SQUOTE = 8'h27;
	localparam byte_t CH_DQUOTE = 8'h22;

	// One result beat.
	typedef struct packed {
		kind_t token_kind;
		byte_t char_value;
		logic  char_valid;
		logic  token_end;
		logic  last_of_input;
	} result_t;

	function automatic logic is_alpha_u(byte_t b);
		return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) || b == CH_UNDER;
	endfunction

	function automatic logic is_num(byte_t b);
		return b >= 8'h30 && b <= 8'h39;
	endfunction

	// Kind of a byte that forms a token on its own.
	function automatic kind_t single_kind(byte_t b);
		kind_t k;
		unique case (b)
			8'h20, 8'h09, 8'h0D: k = K_SPACE;
			8'h0A: k = K_NEWLINE;
			8'h3B: k = K_SEMI;
			8'h28: k = K_LPAREN;
			8'h29: k = K_RPAREN;
			8'h2C: k = K_COMMA;
			8'h2B: k = K_PLUS;
			8'h2D: k = K_MINUS;
			8'h2F: k = K_SLASH;
			8'h2A: k = K_STAR;
			8'h3C: k = K_LT;
			8'h3E: k = K_GT;
			8'h7B: k = K_LBRACE;
			8'h7D: k = K_RBRACE;
			8'h5B: k = K_LBRACKET;
			8'h5D: k = K_RBRACKET;
			default: k = K_ILLEGAL;
		endcase
		return k;
	endfunction

	function automatic result_t mk_result(kind_t k, byte_t ch, logic vld, logic fin);
		result_t r;
		r.token_kind    = k;
		r.char_value    = vld ? ch : CH_NUL;
		r.char_valid    = vld;
		r.token_end     = fin;
		r.last_of_input = 1'b0;
		return r;
	endfunction

endpackage

// ===== rtl/stl_src_if.sv =====
// Source byte channel: valid/ready handshake carrying one source byte a beat.
// Depends on stl_pkg.
interface stl_src_if;
	logic          valid;
	logic          ready;
	stl_pkg::byte_t source_byte;

	modport source (output valid, output source_byte, input ready);
	modport sink (input valid, input source_byte, output ready);
endinterface

// ===== rtl/stl_res_if.sv =====
// Result channel: valid/ready handshake carrying one token character a beat.
// Depends on stl_pkg.
interface stl_res_if;
	logic           valid;
	logic           ready;
	stl_pkg::kind_t token_kind;
	stl_pkg::byte_t char_value;
	logic           char_valid;
	logic           token_end;
	logic           last_of_input;

	modport source (output valid, output token_kind, output char_value, output char_valid,
		output token_end, output last_of_input, input ready);
	modport sink (input valid, input token_kind, input char_value, input char_valid,
		input token_end, input last_of_input, output ready);
endinterface

// ===== rtl/streaming_token_lexer_core.sv =====
// Streaming token lexer core: mode register, byte decode and result queue.
// Depends on stl_pkg, stl_src_if and stl_res_if.

// The lexer takes one source byte a cycle while its source side is ready, and
// returns zero, one or two result beats for it. Each accepted byte is decoded
// against the mode register in the same cycle, and its results are written
// into a four-entry result queue that drives the result channel. A byte may
// yield two results (a closed '==' or '!=', a held character or an open
// identifier or integer closed by a byte that itself yields a result, a string
// cut off by end of input); the queue drains one beat a cycle while the
// consumer is ready. The source side is ready while at most two results wait
// in the queue, so a slow consumer stalls the source only once that space is
// taken.
module streaming_token_lexer_core (
	input  logic   clk,
	input  logic   arst_n,
	stl_src_if.sink   src,
	stl_res_if.source res
);

	typedef enum logic [2:0] {
		M_IDLE = 3'd0,
		M_EQ   = 3'd1,
		M_BANG = 3'd2,
		M_ID   = 3'd3,
		M_NUM  = 3'd4,
		M_SQ   = 3'd5,
		M_DQ   = 3'd6
	} mode_t;

	typedef struct packed {
		logic             has;
		stl_pkg::result_t res;
		mode_t            mode;
	} idle_dec_t;

	localparam int Depth = 4;
	localparam int PtrW  = $clog2(Depth);
	localparam int CntW  = $clog2(Depth + 1);

	mode_t                 mode_q;
	mode_t                 mode_d;
	stl_pkg::result_t      queue_q [Depth];
	logic [PtrW-1:0]       wr_ptr_q;
	logic [PtrW-1:0]       rd_ptr_q;
	logic [CntW-1:0]       count_q;
	stl_pkg::result_t      r0;
	stl_pkg::result_t      r1;
	logic [1:0]            push_n;
	logic                  accept;
	logic                  pop;
	stl_pkg::byte_t        b;
	idle_dec_t             idec;

	// Decode of a byte seen between tokens.
	function automatic idle_dec_t idle_step(stl_pkg::byte_t x);
		idle_dec_t d;
		d.has  = 1'b0;
		d.res  = stl_pkg::mk_result(stl_pkg::K_EOF, stl_pkg::CH_NUL, 1'b0, 1'b1);
		d.mode = M_IDLE;
		if (x == stl_pkg::CH_NUL) begin
			d.has = 1'b1;
		end else if (x == stl_pkg::CH_ASSIGN) begin
			d.mode = M_EQ;
		end else if (x == stl_pkg::CH_BANG) begin
			d.mode = M_BANG;
		end else if (x == stl_pkg::CH_SQUOTE) begin
			d.mode = M_SQ;
		end else if (x == stl_pkg::CH_DQUOTE) begin
			d.mode = M_DQ;
		end else if (stl_pkg::is_alpha_u(x)) begin
			d.has  = 1'b1;
			d.mode = M_ID;
			d.res  = stl_pkg::mk_result(stl_pkg::K_IDENT, x, 1'b1, 1'b0);
		end else if (stl_pkg::is_num(x)) begin
			d.has  = 1'b1;
			d.mode = M_NUM;
			d.res  = stl_pkg::mk_result(stl_pkg::K_INT, x, 1'b1, 1'b0);
		end else begin
			d.has = 1'b1;
			d.res = stl_pkg::mk_result(stl_pkg::single_kind(x), x, 1'b1, 1'b1);
		end
		return d;
	endfunction

	assign b      = src.source_byte;
	assign idec   = idle_step(b);
	assign accept = src.valid && src.ready;
	assign pop    = res.valid && res.ready;

	// Results of the byte on the source channel, and the next mode.
	always_comb begin
		r0     = '0;
		r1     = '0;
		push_n = 2'd0;
		mode_d = M_IDLE;
		unique case (mode_q)
			M_EQ, M_BANG: begin
				if (b == stl_pkg::CH_ASSIGN) begin
					r0 = stl_pkg::mk_result((mode_q == M_EQ) ? stl_pkg::K_EQ : stl_pkg::K_NOTEQ,
						(mode_q == M_EQ) ? stl_pkg::CH_ASSIGN : stl_pkg::CH_BANG, 1'b1, 1'b0);
					r1 = stl_pkg::mk_result(r0.token_kind, stl_pkg::CH_ASSIGN, 1'b1, 1'b1);
					push_n = 2'd2;
				end else begin
					r0 = stl_pkg::mk_result((mode_q == M_EQ) ? stl_pkg::K_ASSIGN : stl_pkg::K_BANG,
						(mode_q == M_EQ) ? stl_pkg::CH_ASSIGN : stl_pkg::CH_BANG, 1'b1, 1'b1);
					r1     = idec.res;
					push_n = idec.has ? 2'd2 : 2'd1;
					mode_d = idec.mode;
				end
			end
			M_ID, M_NUM: begin
				if ((mode_q == M_ID) ? stl_pkg::is_alpha_u(b) : stl_pkg::is_num(b)) begin
					r0 = stl_pkg::mk_result((mode_q == M_ID) ? stl_pkg::K_IDENT : stl_pkg::K_INT,
						b, 1'b1, 1'b0);
					push_n = 2'd1;
					mode_d = mode_q;
				end else begin
					r0 = stl_pkg::mk_result((mode_q == M_ID) ? stl_pkg::K_IDENT : stl_pkg::K_INT,
						stl_pkg::CH_NUL, 1'b0, 1'b1);
					r1     = idec.res;
					push_n = idec.has ? 2'd2 : 2'd1;
					mode_d = idec.mode;
				end
			end
			M_SQ, M_DQ: begin
				if (b == ((mode_q == M_SQ) ? stl_pkg::CH_SQUOTE : stl_pkg::CH_DQUOTE)) begin
					r0 = stl_pkg::mk_result(stl_pkg::K_STRING, stl_pkg::CH_NUL, 1'b0, 1'b1);
					push_n = 2'd1;
				end else if (b == stl_pkg::CH_NUL) begin
					// A string cut off by end of input is closed before the eof token.
					r0 = stl_pkg::mk_result(stl_pkg::K_STRING, stl_pkg::CH_NUL, 1'b0, 1'b1);
					r1 = stl_pkg::mk_result(stl_pkg::K_EOF, stl_pkg::CH_NUL, 1'b0, 1'b1);
					push_n = 2'd2;
				end else begin
					r0 = stl_pkg::mk_result(stl_pkg::K_STRING, b, 1'b1, 1'b0);
					push_n = 2'd1;
					mode_d = mode_q;
				end
			end
			default: begin
				r0     = idec.res;
				push_n = idec.has ? 2'd1 : 2'd0;
				mode_d = idec.mode;
			end
		endcase
		// Mark the final result of this byte.
		if (push_n == 2'd1) begin
			r0.last_of_input = 1'b1;
		end
		if (push_n == 2'd2) begin
			r1.last_of_input = 1'b1;
		end
	end

	// Mode register and queue control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= M_IDLE;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (accept) begin
				mode_q   <= mode_d;
				wr_ptr_q <= wr_ptr_q + PtrW'(push_n);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PtrW'(1);
			end
			count_q <= count_q + (accept ? CntW'(push_n) : CntW'(0)) - CntW'(pop);
		end
	end

	// Result queue storage.
	always_ff @(posedge clk) begin
		if (accept && push_n != 2'd0) begin
			queue_q[wr_ptr_q] <= r0;
		end
		if (accept && push_n == 2'd2) begin
			queue_q[wr_ptr_q + PtrW'(1)] <= r1;
		end
	end

	assign src.ready         = count_q <= CntW'(Depth - 2);
	assign res.valid         = count_q != '0;
	assign res.token_kind    = queue_q[rd_ptr_q].token_kind;
	assign res.char_value    = queue_q[rd_ptr_q].char_value;
	assign res.char_valid    = queue_q[rd_ptr_q].char_valid;
	assign res.token_end     = queue_q[rd_ptr_q].token_end;
	assign res.last_of_input = queue_q[rd_ptr_q].last_of_input;

	// The queue never holds more than its depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(Depth))
		else $error("result queue overflow");

	// A byte is only taken while two free entries remain.
	a_room_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> count_q <= CntW'(Depth - 2))
		else $error("byte accepted without room for its results");

	// End of input always returns the lexer to the idle mode.
	a_eof_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept && b == stl_pkg::CH_NUL |=> mode_q == M_IDLE)
		else $error("mode not idle after end of input");

	// Of two results, only the second carries the last-of-input mark.
	a_last_mark: assert property (@(posedge clk) disable iff (!arst_n)
		accept && push_n == 2'd2 |-> !r0.last_of_input && r1.last_of_input)
		else $error("last-of-input mark misplaced");

endmodule
